[sv/hgsp_pkg.sv]
// Shared types, constants and helper functions of the hbox glue set packer.
`default_nettype none

package hgsp_pkg;

    // Number of glue infinity orders kept in the accumulators.
    localparam int FLEX_ORDERS = 4;
    localparam int ORDER_W     = (FLEX_ORDERS > 1) ? $clog2(FLEX_ORDERS) : 1;
    localparam int ORDER_IN_W  = 2;

    localparam int LEN_W      = 32;               // Q16.16 node lengths
    localparam int TARGET_W   = 31;               // unsigned target width
    localparam int MAX_W      = 31;               // height and depth maxima
    localparam int ACC_W      = 40;               // saturating accumulators
    localparam int FRAC_BITS  = 16;
    localparam int GAP_W      = ACC_W;            // |natural - target| fits here
    localparam int FLEX_W     = ACC_W - 1;        // a positive accumulator value
    localparam int DIVIDEND_W = GAP_W + FRAC_BITS;
    localparam int RATIO_W    = 32;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef enum logic [2:0] {
        KIND_GLYPH   = 3'd0,
        KIND_BOX     = 3'd1,
        KIND_GLUE    = 3'd2,
        KIND_KERN    = 3'd3,
        KIND_RULE    = 3'd4,
        KIND_IGNORED = 3'd5
    } t_node_kind;

    typedef enum logic [1:0] {
        SIGN_NONE    = 2'd0,
        SIGN_STRETCH = 2'd1,
        SIGN_SHRINK  = 2'd2
    } t_glue_sign;

    // Totals of the line being packed.
    typedef struct packed {
        t_acc                   natural;
        t_acc [FLEX_ORDERS-1:0] stretch;
        t_acc [FLEX_ORDERS-1:0] shrink;
        logic [MAX_W-1:0]       max_height;
        logic [MAX_W-1:0]       max_depth;
    } t_line_sums;

    // Request to and answer from the serial divider.
    typedef struct packed {
        logic              start;
        logic [GAP_W-1:0]  gap;
        logic [FLEX_W-1:0] flex;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [RATIO_W-1:0] ratio;
    } t_div_rsp;

    // Adds a signed 32-bit length to an accumulator, clamping at its range.
    function automatic t_acc sat_add(input t_acc a, input logic [LEN_W-1:0] b);
        logic [ACC_W:0] sum;
        sum = {a[ACC_W-1], a} + {{(ACC_W+1-LEN_W){b[LEN_W-1]}}, b};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return sum[ACC_W-1:0];
    endfunction

    // Orders above the highest kept order fold onto it.
    function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_IN_W-1:0] o);
        if (o > ORDER_IN_W'(FLEX_ORDERS - 1)) begin
            return ORDER_W'(FLEX_ORDERS - 1);
        end
        return ORDER_W'(o);
    endfunction

    function automatic logic acc_positive(input t_acc a);
        return !a[ACC_W-1] && (a != '0);
    endfunction

    // Flex of the highest order whose total is positive, else order zero.
    function automatic t_acc pick_flex(input t_acc [FLEX_ORDERS-1:0] sums);
        t_acc flex;
        flex = sums[0];
        for (int r = 1; r < FLEX_ORDERS; r++) begin
            if (acc_positive(sums[r])) begin
                flex = sums[r];
            end
        end
        return flex;
    endfunction

endpackage

`default_nettype wire

[sv/hbox_glue_set_packer_core.sv]
// Top level of the hbox glue set packer: line control, result register and ports.
`default_nettype none

// The block packs one horizontal line of typesetting nodes, one word per node, and
// returns one result word when the node marked last has been taken. Each node is
// folded into saturating 40-bit Q24.16 totals of the natural width and of stretch
// and shrink per infinity order, and into the height and depth maxima. At the end
// of a line the block chooses the glue sign and flex and, when glue has to be set,
// starts the bit-serial divider, which produces one quotient bit per cycle, and
// takes its answer; then it loads the output register, first waiting, if need be,
// for a full output register to drain. Input ready stays low from the last node
// until the result has been placed in the output register. The output register
// holds a finished result while the next line is already being accumulated. The
// target width is written through its own channel, which is always ready, and is
// sampled when a line ends; zero selects the natural width and no glue setting.

module hbox_glue_set_packer_core
    import hgsp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Target width register write channel.
    input  wire logic                  i_cfg_valid,
    output      logic                  o_cfg_ready,
    input  wire logic [TARGET_W-1:0]   i_cfg_data,
    // Node input channel.
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire logic [2:0]            i_node_kind,
    input  wire logic [LEN_W-1:0]      i_node_width,
    input  wire logic [LEN_W-1:0]      i_node_height,
    input  wire logic [LEN_W-1:0]      i_node_depth,
    input  wire logic [LEN_W-1:0]      i_stretch_amount,
    input  wire logic [ORDER_IN_W-1:0] i_stretch_order,
    input  wire logic [LEN_W-1:0]      i_shrink_amount,
    input  wire logic [ORDER_IN_W-1:0] i_shrink_order,
    input  wire logic                  i_last_node,
    // Packed box result channel.
    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      logic [LEN_W-1:0]      o_box_width,
    output      logic [MAX_W-1:0]      o_box_height,
    output      logic [MAX_W-1:0]      o_box_depth,
    output      logic [RATIO_W-1:0]    o_glue_ratio,
    output      logic [1:0]            o_glue_sign
);

    typedef enum logic [1:0] {
        S_ACC,
        S_PICK,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state,     n_state;
    logic [TARGET_W-1:0] r_target;
    logic               r_div_start, n_div_start;
    logic [GAP_W-1:0]   r_gap,       n_gap;
    logic [FLEX_W-1:0]  r_flex,      n_flex;
    logic [LEN_W-1:0]   r_width,     n_width;
    logic [MAX_W-1:0]   r_height,    n_height;
    logic [MAX_W-1:0]   r_depth,     n_depth;
    t_glue_sign         r_sign,      n_sign;
    logic [RATIO_W-1:0] r_ratio,     n_ratio;
    logic               r_out_valid, n_out_valid;
    logic [LEN_W-1:0]   r_out_width, n_out_width;
    logic [MAX_W-1:0]   r_out_height, n_out_height;
    logic [MAX_W-1:0]   r_out_depth, n_out_depth;
    logic [RATIO_W-1:0] r_out_ratio, n_out_ratio;
    t_glue_sign         r_out_sign,  n_out_sign;

    logic               in_accept;
    logic               clear_line;
    t_line_sums         sums;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    t_acc               stretch_flex;
    t_acc               shrink_flex;
    logic [ACC_W:0]     short_by;
    logic [ACC_W:0]     long_by;
    logic               is_short;
    logic               is_long;
    logic [LEN_W-1:0]   natural_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid) begin
            r_target <= i_cfg_data;
        end
    end

    assign o_in_ready = (r_state == S_ACC);
    assign in_accept  = i_in_valid && o_in_ready;
    assign clear_line = (r_state == S_PICK);

    hgsp_accum u_accum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_clear          (clear_line),
        .i_node_kind      (i_node_kind),
        .i_node_width     (i_node_width),
        .i_node_height    (i_node_height),
        .i_node_depth     (i_node_depth),
        .i_stretch_amount (i_stretch_amount),
        .i_stretch_order  (i_stretch_order),
        .i_shrink_amount  (i_shrink_amount),
        .i_shrink_order   (i_shrink_order),
        .o_sums           (sums)
    );

    assign div_req.start = r_div_start;
    assign div_req.gap   = r_gap;
    assign div_req.flex  = r_flex;

    hgsp_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Line-end decision, evaluated in the cycle after the last node, when the
    // totals already include it. Both differences are formed side by side so
    // that the gap needs no negation after the compare.
    assign stretch_flex = pick_flex(sums.stretch);
    assign shrink_flex  = pick_flex(sums.shrink);
    assign short_by = {{(ACC_W+1-TARGET_W){1'b0}}, r_target}
                    - {sums.natural[ACC_W-1], sums.natural};
    assign long_by  = {sums.natural[ACC_W-1], sums.natural}
                    - {{(ACC_W+1-TARGET_W){1'b0}}, r_target};
    assign is_short = !short_by[ACC_W] && (short_by != '0);
    assign is_long  = short_by[ACC_W];

    // Natural width clamped to the signed 32-bit range.
    always_comb begin
        if (!sums.natural[ACC_W-1] && (sums.natural[ACC_W-2:LEN_W-1] != '0)) begin
            natural_sat = {1'b0, {(LEN_W-1){1'b1}}};
        end else if (sums.natural[ACC_W-1] && (sums.natural[ACC_W-2:LEN_W-1] != '1)) begin
            natural_sat = {1'b1, {(LEN_W-1){1'b0}}};
        end else begin
            natural_sat = sums.natural[LEN_W-1:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_div_start  = 1'b0;
        n_gap        = r_gap;
        n_flex       = r_flex;
        n_width      = r_width;
        n_height     = r_height;
        n_depth      = r_depth;
        n_sign       = r_sign;
        n_ratio      = r_ratio;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_width  = r_out_width;
        n_out_height = r_out_height;
        n_out_depth  = r_out_depth;
        n_out_ratio  = r_out_ratio;
        n_out_sign   = r_out_sign;

        case (r_state)
            S_ACC: begin
                if (in_accept && i_last_node) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_height = sums.max_height;
                n_depth  = sums.max_depth;
                n_ratio  = '0;
                n_sign   = SIGN_NONE;
                if (r_target != '0) begin
                    n_width = {1'b0, r_target};
                    if (is_short && acc_positive(stretch_flex)) begin
                        n_sign = SIGN_STRETCH;
                        n_gap  = short_by[GAP_W-1:0];
                        n_flex = stretch_flex[FLEX_W-1:0];
                    end else if (is_long && acc_positive(shrink_flex)) begin
                        n_sign = SIGN_SHRINK;
                        n_gap  = long_by[GAP_W-1:0];
                        n_flex = shrink_flex[FLEX_W-1:0];
                    end
                end else begin
                    n_width = natural_sat;
                end
                if (n_sign != SIGN_NONE) begin
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_ratio = div_rsp.ratio;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Wait until the output register is free or being emptied.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_width  = r_width;
                    n_out_height = r_height;
                    n_out_depth  = r_depth;
                    n_out_ratio  = r_ratio;
                    n_out_sign   = r_sign;
                    n_state      = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
        r_gap        <= n_gap;
        r_flex       <= n_flex;
        r_width      <= n_width;
        r_height     <= n_height;
        r_depth      <= n_depth;
        r_sign       <= n_sign;
        r_ratio      <= n_ratio;
        r_out_width  <= n_out_width;
        r_out_height <= n_out_height;
        r_out_depth  <= n_out_depth;
        r_out_ratio  <= n_out_ratio;
        r_out_sign   <= n_out_sign;
    end

    assign o_out_valid  = r_out_valid;
    assign o_box_width  = r_out_width;
    assign o_box_height = r_out_height;
    assign o_box_depth  = r_out_depth;
    assign o_glue_ratio = r_out_ratio;
    assign o_glue_sign  = r_out_sign;

endmodule

`default_nettype wire

[sv/hgsp_accum.sv]
// Per-line accumulators: natural width, flex per order, height and depth maxima.
`default_nettype none

module hgsp_accum
    import hgsp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic                  i_clear,
    input  wire logic [2:0]            i_node_kind,
    input  wire logic [LEN_W-1:0]      i_node_width,
    input  wire logic [LEN_W-1:0]      i_node_height,
    input  wire logic [LEN_W-1:0]      i_node_depth,
    input  wire logic [LEN_W-1:0]      i_stretch_amount,
    input  wire logic [ORDER_IN_W-1:0] i_stretch_order,
    input  wire logic [LEN_W-1:0]      i_shrink_amount,
    input  wire logic [ORDER_IN_W-1:0] i_shrink_order,
    output t_line_sums                 o_sums
);

    t_acc                   r_natural,  n_natural;
    t_acc [FLEX_ORDERS-1:0] r_stretch,  n_stretch;
    t_acc [FLEX_ORDERS-1:0] r_shrink,   n_shrink;
    logic [MAX_W-1:0]       r_max_h,    n_max_h;
    logic [MAX_W-1:0]       r_max_d,    n_max_d;
    logic [ORDER_W-1:0]     so;
    logic [ORDER_W-1:0]     ko;

    assign so = clamp_order(i_stretch_order);
    assign ko = clamp_order(i_shrink_order);

    always_comb begin
        n_natural = r_natural;
        n_stretch = r_stretch;
        n_shrink  = r_shrink;
        n_max_h   = r_max_h;
        n_max_d   = r_max_d;
        if (i_clear) begin
            n_natural = '0;
            n_stretch = '0;
            n_shrink  = '0;
            n_max_h   = '0;
            n_max_d   = '0;
        end else if (i_accept) begin
            case (i_node_kind)
                KIND_GLYPH, KIND_BOX, KIND_RULE: begin
                    n_natural = sat_add(r_natural, i_node_width);
                    // A negative height or depth never lowers the maximum.
                    if (!i_node_height[LEN_W-1] && (i_node_height[MAX_W-1:0] > r_max_h)) begin
                        n_max_h = i_node_height[MAX_W-1:0];
                    end
                    if (!i_node_depth[LEN_W-1] && (i_node_depth[MAX_W-1:0] > r_max_d)) begin
                        n_max_d = i_node_depth[MAX_W-1:0];
                    end
                end
                KIND_GLUE: begin
                    n_natural     = sat_add(r_natural, i_node_width);
                    n_stretch[so] = sat_add(r_stretch[so], i_stretch_amount);
                    n_shrink[ko]  = sat_add(r_shrink[ko], i_shrink_amount);
                end
                KIND_KERN: begin
                    n_natural = sat_add(r_natural, i_node_width);
                end
                KIND_IGNORED: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_natural <= '0;
            r_stretch <= '0;
            r_shrink  <= '0;
            r_max_h   <= '0;
            r_max_d   <= '0;
        end else begin
            r_natural <= n_natural;
            r_stretch <= n_stretch;
            r_shrink  <= n_shrink;
            r_max_h   <= n_max_h;
            r_max_d   <= n_max_d;
        end
    end

    assign o_sums.natural    = r_natural;
    assign o_sums.stretch    = r_stretch;
    assign o_sums.shrink     = r_shrink;
    assign o_sums.max_height = r_max_h;
    assign o_sums.max_depth  = r_max_d;

endmodule

`default_nettype wire

[sv/hgsp_divider.sv]
// Bit-serial restoring divider that forms the saturated Q16.16 glue ratio.
`default_nettype none

module hgsp_divider
    import hgsp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                  r_busy,  n_busy;
    logic                  r_done,  n_done;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [DIVIDEND_W-1:0] r_dvd,   n_dvd;
    logic [FLEX_W-1:0]     r_rem,   n_rem;
    logic [RATIO_W-1:0]    r_quot,  n_quot;
    logic                  r_ovf,   n_ovf;
    logic [FLEX_W:0]       shifted;
    logic [FLEX_W+1:0]     trial;
    logic                  qbit;

    // One quotient bit per cycle, most significant first.
    assign shifted = {r_rem, r_dvd[DIVIDEND_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, i_req.flex};
    assign qbit    = !trial[FLEX_W+1];

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_count = r_count;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_ovf   = r_ovf;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_count = '0;
            n_dvd   = {i_req.gap, {FRAC_BITS{1'b0}}};
            n_rem   = '0;
            n_quot  = '0;
            n_ovf   = 1'b0;
        end else if (r_busy) begin
            n_dvd   = {r_dvd[DIVIDEND_W-2:0], 1'b0};
            n_rem   = qbit ? trial[FLEX_W-1:0] : shifted[FLEX_W-1:0];
            n_quot  = {r_quot[RATIO_W-2:0], qbit};
            // Any set bit pushed out of the top means the ratio saturates.
            n_ovf   = r_ovf | r_quot[RATIO_W-1];
            n_count = r_count + CNT_W'(1);
            if (r_count == CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_count <= n_count;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_quot  <= n_quot;
        r_ovf   <= n_ovf;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.ratio = r_ovf ? {RATIO_W{1'b1}} : r_quot;

endmodule

`default_nettype wire
